// ----- rtl/tdrr_pkg.sv -----
// ----------------------------------------------------------------------------
// tdrr_pkg
// Types and codes shared by the tick delay round-robin scheduler modules.
// ----------------------------------------------------------------------------
package tdrr_pkg;

    localparam int OPCODE_W = 2;
    localparam int TICK_W   = 32;
    localparam int TASK_W   = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK   = 2'd0,
        OP_DELAY  = 2'd1,
        OP_SWITCH = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

// ----- rtl/tdrr_ctrl.sv -----
// ----------------------------------------------------------------------------
// tdrr_ctrl
// Sequencer: captures an item, runs the execute state, then strobes done.
// ----------------------------------------------------------------------------
module tdrr_ctrl
    import tdrr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load  = 1'b0;
        cmd.exec  = 1'b0;
        busy      = 1'b0;
        done_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_EXEC:
            begin
                cmd.exec  = 1'b1;
                busy      = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// ----- rtl/tdrr_datapath.sv -----
// ----------------------------------------------------------------------------
// tdrr_datapath
// Tick counter, per-task blocked flags and wake ticks, wake compare and
// round-robin pick of the next ready user task.
// ----------------------------------------------------------------------------
module tdrr_datapath
    import tdrr_pkg::*;
#(
    parameter int TASK_COUNT = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [TICK_W-1:0]   delay_ticks,
    output logic [TASK_W-1:0]   current_task,
    output logic                pend_switch,
    output logic [TICK_W-1:0]   tick_now
);

    localparam int TW = (TASK_COUNT > 2) ? $clog2(TASK_COUNT) : 1;

    logic [OPCODE_W-1:0]   op_reg;
    logic [TICK_W-1:0]     delay_reg;
    logic [TICK_W-1:0]     tick_reg;
    logic [TICK_W-1:0]     tick_next;
    logic [TASK_COUNT-1:0] blocked_reg;
    logic [TASK_COUNT-1:0] blocked_next;
    logic [TW-1:0]         running_reg;
    logic [TW-1:0]         running_next;
    logic                  pend_reg;
    logic                  pend_next;
    logic [TICK_W-1:0]     wake_reg [TASK_COUNT];
    logic                  wake_we;

    logic [TICK_W-1:0]     tick_inc;
    logic [TICK_W-1:0]     wake_value;
    logic [TASK_COUNT-1:0] due;
    logic [TASK_COUNT-1:0] ready_user;
    logic [TASK_COUNT-1:0] ready_after;
    logic [TASK_COUNT-1:0] pick_vec;
    logic [TASK_COUNT-1:0] pick_onehot;
    logic [TW-1:0]         pick_idx;
    logic [31:0]           running_wide;

    assign tick_inc   = tick_reg + TICK_W'(1);
    assign wake_value = tick_reg + delay_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            delay_reg <= delay_ticks;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wake_we)
        begin
            wake_reg[running_reg] <= wake_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= '0;
            blocked_reg <= '0;
            running_reg <= TW'(1);
            pend_reg    <= 1'b0;
        end
        else if (cmd.exec)
        begin
            tick_reg    <= tick_next;
            blocked_reg <= blocked_next;
            running_reg <= running_next;
            pend_reg    <= pend_next;
        end
    end

    // wake compare and ready vectors, one lane per task
    always_comb
    begin
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            if (i == 0)
            begin
                due[i]         = 1'b0;
                ready_user[i]  = 1'b0;
                ready_after[i] = 1'b0;
            end
            else
            begin
                due[i]         = blocked_reg[i] && (tick_inc >= wake_reg[i]);
                ready_user[i]  = !blocked_reg[i];
                ready_after[i] = !blocked_reg[i] && (TW'(i) > running_reg);
            end
        end
    end

    // round-robin: first ready task above the current one, else lowest ready
    assign pick_vec    = (ready_after != '0) ? ready_after : ready_user;
    assign pick_onehot = pick_vec & (~pick_vec + TASK_COUNT'(1));

    always_comb
    begin
        pick_idx = '0;
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            if (pick_onehot[i])
            begin
                pick_idx = pick_idx | TW'(i);
            end
        end
    end

    always_comb
    begin
        tick_next    = tick_reg;
        blocked_next = blocked_reg;
        running_next = running_reg;
        pend_next    = 1'b0;
        wake_we      = 1'b0;
        case (op_reg)
            OP_TICK:
            begin
                tick_next    = tick_inc;
                blocked_next = blocked_reg & ~due;
                pend_next    = 1'b1;
            end
            OP_DELAY:
            begin
                if (running_reg != '0)
                begin
                    wake_we                   = 1'b1;
                    blocked_next[running_reg] = 1'b1;
                    pend_next                 = 1'b1;
                end
            end
            OP_SWITCH:
            begin
                running_next = pick_idx;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    assign running_wide = 32'(running_reg);
    assign current_task = running_wide[TASK_W-1:0];
    assign pend_switch  = pend_reg;
    assign tick_now     = tick_reg;

endmodule

// ----- rtl/tick_delay_round_robin_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// tick_delay_round_robin_scheduler_core
// Round-robin task scheduler with tick-based delays; task 0 is idle.
// ----------------------------------------------------------------------------
// Each item passes a capture state, which takes the command, and an execute
// state, in which the datapath runs the tick wake compare over all tasks in
// parallel, the delay update or the round-robin pick and updates its state.
// done pulses for one cycle right after, with busy already low, so start can
// be taken again in the done cycle. Results are held on the ports until the
// next item executes and cannot be stalled; capture them on done.
module tick_delay_round_robin_scheduler_core
    import tdrr_pkg::*;
#(
    parameter int TASK_COUNT = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [TICK_W-1:0]   delay_ticks,
    output logic                done,
    output logic [TASK_W-1:0]   current_task,
    output logic                pend_switch,
    output logic [TICK_W-1:0]   tick_now
);

    cmd_t cmd;

    tdrr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    tdrr_datapath #(
        .TASK_COUNT (TASK_COUNT)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .opcode       (opcode),
        .delay_ticks  (delay_ticks),
        .current_task (current_task),
        .pend_switch  (pend_switch),
        .tick_now     (tick_now)
    );

    a_accept_then_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done
    ) else $error("item accepted without done two cycles later");

    a_done_not_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (!busy && !cmd.exec)
    ) else $error("done while still executing");

    a_exec_after_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.exec |-> $past(cmd.load)
    ) else $error("execute cycle without a captured item");

    a_tick_only_on_tick: assert property (
        @(posedge clk) disable iff (!rst_n)
        !$past(cmd.exec) |-> $stable(tick_now)
    ) else $error("tick counter moved outside an execute cycle");

endmodule
